// ===== rtl/hsl_to_rgb_pixel_converter_core_defines.svh =====
// Assertion macros for the HSL to RGB pixel converter checker.
// No dependencies; included by the checker file.
`ifndef HSL_TO_RGB_PIXEL_CONVERTER_CORE_DEFINES_SVH
`define HSL_TO_RGB_PIXEL_CONVERTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define HSL2RGB_AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hsl2rgb check failed");

// Next-cycle implication, disabled while reset is low.
`define HSL2RGB_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hsl2rgb check failed");

`endif

// ===== rtl/hsl2rgb_pkg.sv =====
// Package for the HSL to RGB pixel converter: fixed-point widths, sextant codes,
// byte-to-unit scaling and hue splitting functions. No dependencies.
package hsl2rgb_pkg;

    localparam int FRAC_BITS = 16;
    localparam int FX_W      = FRAC_BITS + 1;
    localparam int SUM_W     = FRAC_BITS + 2;
    localparam int PROD_W    = 2 * FX_W;
    localparam int SCL_W     = SUM_W + 8;

    typedef logic [FRAC_BITS-1:0] t_frac;
    typedef logic [FX_W-1:0]      t_fx;

    localparam t_fx        FX_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [7:0] BYTE_MAX = 8'd255;
    localparam logic [2:0] HUE_LAST = 3'd6;

    typedef enum logic [2:0] {
        SEXT_RY = 3'd0,
        SEXT_YG = 3'd1,
        SEXT_GC = 3'd2,
        SEXT_CB = 3'd3,
        SEXT_BM = 3'd4,
        SEXT_MR = 3'd5
    } t_sextant;

    typedef struct packed {
        logic [2:0] q;
        logic [7:0] r;
    } t_hue_split;

    // floor(r * 2^FRAC_BITS / 255) for r < 255: the byte repeated as a binary fraction
    function automatic t_frac rep_frac(input logic [7:0] r);
        t_frac f;
        for (int i = 0; i < FRAC_BITS; i++) begin
            f[FRAC_BITS-1-i] = r[7 - (i % 8)];
        end
        return f;
    endfunction

    function automatic t_fx unit_scale(input logic [7:0] x);
        t_fx v;
        if (x == BYTE_MAX) begin
            v = FX_ONE;
        end else begin
            v = {1'b0, rep_frac(x)};
        end
        return v;
    endfunction

    // split 6*h into 255*q + r
    function automatic t_hue_split hue_split(input logic [7:0] h);
        logic [10:0] x;
        logic [2:0]  q;
        t_hue_split  s;
        x = (11'(h) << 2) + (11'(h) << 1);
        q = 3'd0;
        for (int k = 1; k <= 6; k++) begin
            if (x >= 11'(255 * k)) begin
                q = 3'(k);
            end
        end
        s.q = q;
        s.r = 8'(x - ((11'(q) << 8) - 11'(q)));
        return s;
    endfunction

endpackage

// ===== rtl/hsl_to_rgb_pixel_converter_core.sv =====
// HSL to RGB pixel converter, four-stage pipeline; uses hsl2rgb_pkg.
// Throughput: one word per cycle while the receiver keeps i_ready high; each stage
// holds one word and advances when the stage after it is empty or advancing; two
// multipliers sit in stages 2 and 3.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
module hsl_to_rgb_pixel_converter_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_hue_code,
    input  logic [7:0] i_saturation,
    input  logic [7:0] i_lightness,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    function automatic logic [7:0] to_byte(input hsl2rgb_pkg::t_fx comp,
                                           input hsl2rgb_pkg::t_fx off);
        logic [hsl2rgb_pkg::SUM_W-1:0] sum;
        logic [hsl2rgb_pkg::SCL_W-1:0] t;
        logic [hsl2rgb_pkg::SCL_W-hsl2rgb_pkg::FRAC_BITS-1:0] s;
        sum = hsl2rgb_pkg::SUM_W'(comp) + hsl2rgb_pkg::SUM_W'(off);
        t   = (hsl2rgb_pkg::SCL_W'(sum) << 8) - hsl2rgb_pkg::SCL_W'(sum);
        s   = t[hsl2rgb_pkg::SCL_W-1:hsl2rgb_pkg::FRAC_BITS];
        if (s > (hsl2rgb_pkg::SCL_W-hsl2rgb_pkg::FRAC_BITS)'(hsl2rgb_pkg::BYTE_MAX)) begin
            return hsl2rgb_pkg::BYTE_MAX;
        end
        return s[7:0];
    endfunction

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // stage 1: scale bytes, split hue, form chroma and secondary factors
    hsl2rgb_pkg::t_hue_split        hs;
    hsl2rgb_pkg::t_fx               n_lf, n_sf, n_a, n_w;
    logic [hsl2rgb_pkg::SUM_W-1:0]  dbl_lf;
    hsl2rgb_pkg::t_sextant          n_sext;

    always_comb begin
        hs     = hsl2rgb_pkg::hue_split(i_hue_code);
        n_lf   = hsl2rgb_pkg::unit_scale(i_lightness);
        n_sf   = hsl2rgb_pkg::unit_scale(i_saturation);
        dbl_lf = {n_lf, 1'b0};
        if (n_lf[hsl2rgb_pkg::FRAC_BITS] || n_lf[hsl2rgb_pkg::FRAC_BITS-1]) begin
            n_a = hsl2rgb_pkg::FX_W'({hsl2rgb_pkg::FX_ONE, 1'b0} - dbl_lf);
        end else begin
            n_a = hsl2rgb_pkg::FX_W'(dbl_lf);
        end
        if (hs.q[0]) begin
            n_w = hsl2rgb_pkg::FX_ONE - {1'b0, hsl2rgb_pkg::rep_frac(hs.r)};
        end else begin
            n_w = {1'b0, hsl2rgb_pkg::rep_frac(hs.r)};
        end
        if (hs.q >= hsl2rgb_pkg::HUE_LAST) begin
            n_sext = hsl2rgb_pkg::SEXT_MR;
        end else begin
            n_sext = hsl2rgb_pkg::t_sextant'(hs.q);
        end
    end

    hsl2rgb_pkg::t_fx      r_s1_lf, r_s1_sf, r_s1_a, r_s1_w;
    hsl2rgb_pkg::t_sextant r_s1_sext;

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_lf   <= n_lf;
            r_s1_sf   <= n_sf;
            r_s1_a    <= n_a;
            r_s1_w    <= n_w;
            r_s1_sext <= n_sext;
        end
    end

    // stage 2: chroma
    logic [hsl2rgb_pkg::PROD_W-1:0] n_cprod;
    hsl2rgb_pkg::t_fx               r_s2_chroma, r_s2_lf, r_s2_w;
    hsl2rgb_pkg::t_sextant          r_s2_sext;

    assign n_cprod = hsl2rgb_pkg::PROD_W'(r_s1_a) * hsl2rgb_pkg::PROD_W'(r_s1_sf);

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_chroma <= n_cprod[hsl2rgb_pkg::FRAC_BITS +: hsl2rgb_pkg::FX_W];
            r_s2_lf     <= r_s1_lf;
            r_s2_w      <= r_s1_w;
            r_s2_sext   <= r_s1_sext;
        end
    end

    // stage 3: secondary component and offset
    logic [hsl2rgb_pkg::PROD_W-1:0] n_xprod;
    hsl2rgb_pkg::t_fx               n_off;
    hsl2rgb_pkg::t_fx               r_s3_chroma, r_s3_second, r_s3_off;
    hsl2rgb_pkg::t_sextant          r_s3_sext;

    assign n_xprod = hsl2rgb_pkg::PROD_W'(r_s2_chroma) * hsl2rgb_pkg::PROD_W'(r_s2_w);
    assign n_off   = r_s2_lf - (r_s2_chroma >> 1);

    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_chroma <= r_s2_chroma;
            r_s3_second <= n_xprod[hsl2rgb_pkg::FRAC_BITS +: hsl2rgb_pkg::FX_W];
            r_s3_off    <= n_off;
            r_s3_sext   <= r_s2_sext;
        end
    end

    // stage 4: order components, add offset, scale to bytes
    hsl2rgb_pkg::t_fx r1, g1, b1;
    logic [7:0]       n_red, n_green, n_blue;

    always_comb begin
        case (r_s3_sext)
            hsl2rgb_pkg::SEXT_RY: begin
                r1 = r_s3_chroma; g1 = r_s3_second; b1 = '0;
            end
            hsl2rgb_pkg::SEXT_YG: begin
                r1 = r_s3_second; g1 = r_s3_chroma; b1 = '0;
            end
            hsl2rgb_pkg::SEXT_GC: begin
                r1 = '0; g1 = r_s3_chroma; b1 = r_s3_second;
            end
            hsl2rgb_pkg::SEXT_CB: begin
                r1 = '0; g1 = r_s3_second; b1 = r_s3_chroma;
            end
            hsl2rgb_pkg::SEXT_BM: begin
                r1 = r_s3_second; g1 = '0; b1 = r_s3_chroma;
            end
            default: begin
                r1 = r_s3_chroma; g1 = '0; b1 = r_s3_second;
            end
        endcase
        n_red   = to_byte(r1, r_s3_off);
        n_green = to_byte(g1, r_s3_off);
        n_blue  = to_byte(b1, r_s3_off);
    end

    logic [7:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ===== rtl/hsl2rgb_checker.sv =====
// Port-level checker for hsl_to_rgb_pixel_converter_core, bound into that core module.
// Depends on hsl_to_rgb_pixel_converter_core_defines.svh for the assertion macros.
`include "hsl_to_rgb_pixel_converter_core_defines.svh"

module hsl2rgb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_saturation,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);

    `HSL2RGB_AST_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_red) && $stable(o_green) && $stable(o_blue))

    `HSL2RGB_AST_IMPL(a_reset_empty, i_clk, i_rst_n, !$past(i_rst_n), !o_valid)

    `HSL2RGB_AST_IMPL(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)

    `HSL2RGB_AST_NEXT(a_latency, i_clk, i_rst_n, i_valid && o_ready ##1 i_ready ##1 i_ready ##1 i_ready, o_valid)

    `HSL2RGB_AST_NEXT(a_gray, i_clk, i_rst_n, i_valid && o_ready && i_saturation == 8'd0 ##1 i_ready ##1 i_ready ##1 i_ready, o_red == o_green && o_green == o_blue)

endmodule

bind hsl_to_rgb_pixel_converter_core hsl2rgb_checker u_hsl2rgb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_saturation(i_saturation),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue)
);

// ===== verif/tb_hsl_to_rgb_pixel_converter_core.sv =====
// Self-checking testbench for hsl_to_rgb_pixel_converter_core: drives HSL pixel words
// with bursty valid and a stalling receiver, checks each RGB word against a fixed-point
// prediction held in a small scoreboard class. Depends on hsl2rgb_pkg and the core RTL.

typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
} rgb_word_t;

class rgb_scoreboard;
    localparam longint UNIT = 64'sd1 <<< hsl2rgb_pkg::FRAC_BITS;

    rgb_word_t pending_rgb[$];
    int        mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    static function logic [7:0] channel_byte(longint comp, longint offs);
        longint sum;
        longint scaled;
        sum = comp + offs;
        if (sum <= 0) begin
            return 8'd0;
        end
        scaled = (sum * 255) / UNIT;
        if (scaled > 255) begin
            scaled = 255;
        end
        return 8'(scaled);
    endfunction

    static function rgb_word_t convert_hsl(logic [7:0] h, logic [7:0] s, logic [7:0] l);
        longint lf, sf, hp, span, chroma, hue_mod, second, offs;
        longint comp_r, comp_g, comp_b;
        hsl2rgb_pkg::t_sextant sext;
        rgb_word_t res;
        lf = (longint'(l) * UNIT) / 255;
        sf = (longint'(s) * UNIT) / 255;
        hp = (longint'(h) * 6 * UNIT) / 255;
        span = 2 * lf - UNIT;
        if (span < 0) begin
            span = -span;
        end
        chroma = ((UNIT - span) * sf) / UNIT;
        hue_mod = hp % (2 * UNIT);
        span = hue_mod - UNIT;
        if (span < 0) begin
            span = -span;
        end
        second = (chroma * (UNIT - span)) / UNIT;
        offs = lf - chroma / 2;
        // hold full-circle hue in the last sextant
        if (hp / UNIT > 5) begin
            sext = hsl2rgb_pkg::SEXT_MR;
        end else begin
            sext = hsl2rgb_pkg::t_sextant'(3'(hp / UNIT));
        end
        case (sext)
            hsl2rgb_pkg::SEXT_RY: begin
                comp_r = chroma; comp_g = second; comp_b = 0;
            end
            hsl2rgb_pkg::SEXT_YG: begin
                comp_r = second; comp_g = chroma; comp_b = 0;
            end
            hsl2rgb_pkg::SEXT_GC: begin
                comp_r = 0; comp_g = chroma; comp_b = second;
            end
            hsl2rgb_pkg::SEXT_CB: begin
                comp_r = 0; comp_g = second; comp_b = chroma;
            end
            hsl2rgb_pkg::SEXT_BM: begin
                comp_r = second; comp_g = 0; comp_b = chroma;
            end
            default: begin
                comp_r = chroma; comp_g = 0; comp_b = second;
            end
        endcase
        res.red   = channel_byte(comp_r, offs);
        res.green = channel_byte(comp_g, offs);
        res.blue  = channel_byte(comp_b, offs);
        return res;
    endfunction

    function void note_pixel(logic [7:0] h, logic [7:0] s, logic [7:0] l);
        pending_rgb.push_back(convert_hsl(h, s, l));
    endfunction

    function void check_rgb(rgb_word_t got);
        rgb_word_t exp_rgb;
        if (pending_rgb.size() == 0) begin
            if (mismatch_count < 10) begin
                $display("unexpected RGB word r=%0d g=%0d b=%0d", got.red, got.green,
                         got.blue);
            end
            mismatch_count++;
            return;
        end
        exp_rgb = pending_rgb.pop_front();
        if (got.red !== exp_rgb.red || got.green !== exp_rgb.green ||
            got.blue !== exp_rgb.blue) begin
            if (mismatch_count < 10) begin
                $display("RGB mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                         exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                         got.red, got.green, got.blue);
            end
            mismatch_count++;
        end
    endfunction

    function int pending();
        return pending_rgb.size();
    endfunction
endclass

module tb_hsl_to_rgb_pixel_converter_core;
    localparam int STALL_LIMIT = 2000;
    localparam int PIXEL_COUNT = 1350;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_hue_code;
    logic [7:0] i_saturation;
    logic [7:0] i_lightness;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    rgb_scoreboard sb;

    hsl_to_rgb_pixel_converter_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_hue_code   (i_hue_code),
        .i_saturation (i_saturation),
        .i_lightness  (i_lightness),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [7:0] pick_byte();
        logic [7:0] v;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0:       v = 8'd0;
                1:       v = 8'd255;
                2:       v = 8'd127;
                default: v = 8'd128;
            endcase
        end else begin
            v = 8'($urandom_range(0, 255));
        end
        return v;
    endfunction

    task automatic send_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] l);
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_hue_code   <= h;
        i_saturation <= s;
        i_lightness  <= l;
        @(posedge i_clk);
        while (o_ready !== 1'b1) begin
            @(posedge i_clk);
        end
        sb.note_pixel(h, s, l);
    endtask

    task automatic hold_idle(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid      <= 1'b0;
            i_hue_code   <= 8'($urandom);
            i_saturation <= 8'($urandom);
            i_lightness  <= 8'($urandom);
        end
    endtask

    task automatic wait_drained();
        hold_idle(1);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // receiver stall pattern
    initial begin
        int stall_mode;
        int tick;
        i_ready    = 1'b0;
        stall_mode = 0;
        tick       = 0;
        forever begin
            @(negedge i_clk);
            if (tick % 150 == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            tick++;
            case (stall_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 3) != 0);
                2:       i_ready <= ((tick % 9) < 4);
                default: i_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            sb.check_rgb(rgb_word_t'{o_red, o_green, o_blue});
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid === 1'b1 && o_ready === 1'b1) ||
                (o_valid === 1'b1 && i_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[hsl_to_rgb_pixel_converter_core] ERROR");
        $finish;
    end

    initial begin
        logic [23:0] corner_pixels[] = '{
            24'h00_00_00, 24'hFF_FF_FF, 24'h00_FF_80, 24'h2A_FF_80, 24'h2B_FF_80,
            24'h55_FF_80, 24'h56_FF_80, 24'h7F_FF_80, 24'h80_FF_80, 24'hAA_FF_80,
            24'hAB_FF_80, 24'hD4_FF_80, 24'hD5_FF_80, 24'hFF_FF_80, 24'hFE_FF_80,
            24'h40_00_80, 24'h40_FF_00, 24'h40_FF_FF, 24'h40_FF_7F, 24'h14_C0_40,
            24'h99_80_E0, 24'h00_FF_FF, 24'hFF_00_00, 24'h01_01_01
        };
        int  sent;
        int  burst;
        bit  paused_mid;
        sb           = new();
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_hue_code   = 8'd0;
        i_saturation = 8'd0;
        i_lightness  = 8'd0;
        sent         = 0;
        paused_mid   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (corner_pixels[i]) begin
            send_pixel(corner_pixels[i][23:16], corner_pixels[i][15:8], corner_pixels[i][7:0]);
        end
        wait_drained();

        while (sent < PIXEL_COUNT) begin
            burst = $urandom_range(1, 32);
            repeat (burst) begin
                send_pixel(pick_byte(), pick_byte(), pick_byte());
            end
            sent += burst;
            if (!paused_mid && sent > PIXEL_COUNT / 2) begin
                paused_mid = 1'b1;
                wait_drained();
            end else if ($urandom_range(0, 3) != 0) begin
                hold_idle($urandom_range(1, 10));
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("[hsl_to_rgb_pixel_converter_core] OK");
        end else begin
            $display("[hsl_to_rgb_pixel_converter_core] ERROR");
        end
        $finish;
    end
endmodule
